### hdl/vfcm_pkg.sv
// Shared constants, types and face tables of the voxel face mesher.
`default_nettype none
package vfcm_pkg;

    localparam int COORD_BITS  = 16;
    localparam int HEIGHT_BITS = 8;
    localparam int LIGHT_BITS  = 8;
    localparam int KIND_BITS   = 8;
    localparam int NB_BITS     = 14;
    localparam int NUM_FACES   = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_BITS  = 4;
    localparam int PDATA_BITS  = 32;

    localparam logic [1:0] REG_FULL_LIGHT      = 2'd0;
    localparam logic [1:0] REG_OCCLUDED_LIGHT  = 2'd1;
    localparam logic [1:0] REG_UNDERSIDE_LIGHT = 2'd2;

    localparam logic [LIGHT_BITS-1:0] FULL_LIGHT_RST      = 8'd255;
    localparam logic [LIGHT_BITS-1:0] OCCLUDED_LIGHT_RST  = 8'd217;
    localparam logic [LIGHT_BITS-1:0] UNDERSIDE_LIGHT_RST = 8'd166;

    localparam logic [2:0] FACE_FRONT  = 3'd0;
    localparam logic [2:0] FACE_LEFT   = 3'd1;
    localparam logic [2:0] FACE_BOTTOM = 3'd2;
    localparam logic [2:0] FACE_RIGHT  = 3'd3;
    localparam logic [2:0] FACE_TOP    = 3'd4;
    localparam logic [2:0] FACE_BACK   = 3'd5;

    localparam int NB_FRONT  = 0;
    localparam int NB_BACK   = 1;
    localparam int NB_LEFT   = 2;
    localparam int NB_RIGHT  = 3;
    localparam int NB_TOP    = 4;
    localparam int NB_BOTTOM = 5;

    localparam logic [NB_BITS-1:0] M_BOTTOM = 14'h0020;
    localparam logic [NB_BITS-1:0] M_OCC_FL = 14'h0540;
    localparam logic [NB_BITS-1:0] M_OCC_FR = 14'h0A40;
    localparam logic [NB_BITS-1:0] M_OCC_BL = 14'h1180;
    localparam logic [NB_BITS-1:0] M_OCC_BR = 14'h2280;

    typedef struct packed {
        logic [COORD_BITS-1:0]  pos_x;
        logic [HEIGHT_BITS-1:0] pos_y;
        logic [COORD_BITS-1:0]  pos_z;
        logic [NB_BITS-1:0]     nb;
        logic [KIND_BITS-1:0]   kind;
        logic [NUM_FACES-1:0]   faces;
    } entry_t;

    typedef struct packed {
        logic [LIGHT_BITS-1:0] full_light;
        logic [LIGHT_BITS-1:0] occluded_light;
        logic [LIGHT_BITS-1:0] underside_light;
    } light_cfg_t;

    // corner code: bit0 dx, bit1 dy, bit2 dz
    function automatic logic [2:0] corner_of(input logic [2:0] face, input logic [1:0] v);
        logic [11:0] row;
        row = 12'd0;
        case (face)
            FACE_FRONT:  row = {3'd2, 3'd3, 3'd1, 3'd0};
            FACE_LEFT:   row = {3'd6, 3'd2, 3'd0, 3'd4};
            FACE_BOTTOM: row = {3'd0, 3'd1, 3'd5, 3'd4};
            FACE_RIGHT:  row = {3'd3, 3'd7, 3'd5, 3'd1};
            FACE_TOP:    row = {3'd6, 3'd7, 3'd3, 3'd2};
            FACE_BACK:   row = {3'd7, 3'd6, 3'd4, 3'd5};
            default:     row = 12'd0;
        endcase
        return row[3*v +: 3];
    endfunction

    function automatic logic [NB_BITS-1:0] occ_of(input logic [2:0] face, input logic [1:0] v);
        logic [4*NB_BITS-1:0] row;
        row = '0;
        case (face)
            FACE_FRONT: row = {M_OCC_FL, M_OCC_FR, M_BOTTOM, M_BOTTOM};
            FACE_LEFT:  row = {M_OCC_BL, M_OCC_FL, M_BOTTOM, M_BOTTOM};
            FACE_RIGHT: row = {M_OCC_FR, M_OCC_BR, M_BOTTOM, M_BOTTOM};
            FACE_TOP:   row = {M_OCC_BL, M_OCC_BR, M_OCC_FR, M_OCC_FL};
            FACE_BACK:  row = {M_OCC_BR, M_OCC_BL, M_BOTTOM, M_BOTTOM};
            default:    row = '0;
        endcase
        return row[NB_BITS*v +: NB_BITS];
    endfunction

endpackage
`default_nettype wire

### hdl/vfcm_front.sv
// Front end: accepts blocks and works out which faces are exposed.
`default_nettype none
module vfcm_front (
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [vfcm_pkg::COORD_BITS-1:0]  s_pos_x,
    input  wire logic [vfcm_pkg::HEIGHT_BITS-1:0] s_pos_y,
    input  wire logic [vfcm_pkg::COORD_BITS-1:0]  s_pos_z,
    input  wire logic [vfcm_pkg::NB_BITS-1:0]     s_neighbor_solid,
    input  wire logic [vfcm_pkg::KIND_BITS-1:0]   s_block_kind,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output vfcm_pkg::entry_t                      q_entry
);

    logic [vfcm_pkg::NUM_FACES-1:0] faces;

    always_comb begin
        faces = '0;
        faces[vfcm_pkg::FACE_FRONT]  = !s_neighbor_solid[vfcm_pkg::NB_FRONT];
        faces[vfcm_pkg::FACE_LEFT]   = !s_neighbor_solid[vfcm_pkg::NB_LEFT];
        faces[vfcm_pkg::FACE_BOTTOM] = !s_neighbor_solid[vfcm_pkg::NB_BOTTOM]
                                       && (s_pos_y != '0);
        faces[vfcm_pkg::FACE_RIGHT]  = !s_neighbor_solid[vfcm_pkg::NB_RIGHT];
        faces[vfcm_pkg::FACE_TOP]    = !s_neighbor_solid[vfcm_pkg::NB_TOP];
        faces[vfcm_pkg::FACE_BACK]   = !s_neighbor_solid[vfcm_pkg::NB_BACK];
    end

    // drop fully hidden blocks here
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && (faces != '0);

    always_comb begin
        q_entry       = '0;
        q_entry.pos_x = s_pos_x;
        q_entry.pos_y = s_pos_y;
        q_entry.pos_z = s_pos_z;
        q_entry.nb    = s_neighbor_solid;
        q_entry.kind  = s_block_kind;
        q_entry.faces = faces;
    end

endmodule
`default_nettype wire

### hdl/vfcm_queue.sv
// Short queue of classified blocks between front and back.
`default_nettype none
module vfcm_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  vfcm_pkg::entry_t      push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output vfcm_pkg::entry_t      head
);

    vfcm_pkg::entry_t mem_reg [vfcm_pkg::QUEUE_DEPTH];
    logic [vfcm_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vfcm_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [vfcm_pkg::QCNT_BITS-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full      = (count_reg == vfcm_pkg::QCNT_BITS'(vfcm_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == vfcm_pkg::QPTR_BITS'(vfcm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == vfcm_pkg::QPTR_BITS'(vfcm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

### hdl/vfcm_back.sv
// Back end: walks the exposed faces and emits one vertex per cycle while m_ready does not stall it.
`default_nettype none
module vfcm_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  vfcm_pkg::light_cfg_t                    cfg,
    input  wire logic                               q_not_empty,
    input  vfcm_pkg::entry_t                        q_head,
    output logic                                    q_pop,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [vfcm_pkg::COORD_BITS:0]    m_vert_x,
    output logic        [vfcm_pkg::HEIGHT_BITS:0]   m_vert_y,
    output logic signed [vfcm_pkg::COORD_BITS:0]    m_vert_z,
    output logic        [vfcm_pkg::LIGHT_BITS-1:0]  m_vert_light,
    output logic        [1:0]                       m_tex_corner,
    output logic        [2:0]                       m_face_id,
    output logic        [vfcm_pkg::KIND_BITS-1:0]   m_kind_out,
    output logic                                    m_last_vertex
);

    localparam int CB = vfcm_pkg::COORD_BITS;
    localparam int HB = vfcm_pkg::HEIGHT_BITS;

    vfcm_pkg::entry_t cur_reg;
    logic [vfcm_pkg::NUM_FACES-1:0] mask_reg, mask_next;
    logic [1:0] vtx_reg, vtx_next;
    logic busy_reg, busy_next;
    logic valid_reg, valid_next;

    logic signed [CB:0]  vx_reg;
    logic [HB:0]         vy_reg;
    logic signed [CB:0]  vz_reg;
    logic [vfcm_pkg::LIGHT_BITS-1:0] light_reg;
    logic [1:0] corner_idx_reg;
    logic [2:0] face_reg;
    logic [vfcm_pkg::KIND_BITS-1:0] kind_reg;
    logic last_reg;

    logic [2:0] face;
    logic [2:0] corner;
    logic [vfcm_pkg::LIGHT_BITS-1:0] light;
    logic [vfcm_pkg::NUM_FACES-1:0] mask_left;
    logic adv, emit, last;

    always_comb begin
        face = vfcm_pkg::FACE_BACK;
        for (int i = vfcm_pkg::NUM_FACES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                face = 3'(i);
            end
        end
    end

    assign corner = vfcm_pkg::corner_of(face, vtx_reg);

    always_comb begin
        if (face == vfcm_pkg::FACE_BOTTOM) begin
            light = cfg.underside_light;
        end else if ((cur_reg.nb & vfcm_pkg::occ_of(face, vtx_reg)) != '0) begin
            light = cfg.occluded_light;
        end else begin
            light = cfg.full_light;
        end
    end

    always_comb begin
        mask_left = mask_reg;
        mask_left[face] = 1'b0;
    end

    assign adv   = !valid_reg || m_ready;
    assign emit  = adv && busy_reg;
    assign last  = (vtx_reg == 2'd3) && (mask_left == '0);
    assign q_pop = q_not_empty && (!busy_reg || (emit && last));

    always_comb begin
        mask_next  = mask_reg;
        vtx_next   = vtx_reg;
        busy_next  = busy_reg;
        valid_next = adv ? emit : valid_reg;
        if (emit) begin
            vtx_next = vtx_reg + 1'b1;
            if (vtx_reg == 2'd3) begin
                mask_next = mask_left;
            end
            if (last) begin
                busy_next = 1'b0;
            end
        end
        if (q_pop) begin
            mask_next = q_head.faces;
            vtx_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            mask_reg  <= '0;
            vtx_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            mask_reg  <= mask_next;
            vtx_reg   <= vtx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
        if (emit) begin
            vx_reg <= $signed({cur_reg.pos_x[CB-1], cur_reg.pos_x})
                      + $signed({{CB{1'b0}}, corner[0]});
            vy_reg <= {1'b0, cur_reg.pos_y} + {{HB{1'b0}}, corner[1]};
            vz_reg <= $signed({cur_reg.pos_z[CB-1], cur_reg.pos_z})
                      + $signed({{CB{1'b0}}, corner[2]});
            light_reg      <= light;
            corner_idx_reg <= vtx_reg;
            face_reg       <= face;
            kind_reg       <= cur_reg.kind;
            last_reg       <= last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_vert_x      = vx_reg;
    assign m_vert_y      = vy_reg;
    assign m_vert_z      = vz_reg;
    assign m_vert_light  = light_reg;
    assign m_tex_corner  = corner_idx_reg;
    assign m_face_id     = face_reg;
    assign m_kind_out    = kind_reg;
    assign m_last_vertex = last_reg;

endmodule
`default_nettype wire

### hdl/voxel_face_cull_occlusion_mesher.sv
// Top level of the voxel face culling and ambient occlusion mesher.
// Each accepted block yields four vertices per exposed face, one vertex per clock cycle from
// the back-end sequencer while m_ready does not stall it; the front end classifies a block
// combinationally and drops a block with no exposed face without producing anything. A
// two-entry queue sits between front and back, so blocks keep being accepted while
// vertices are still draining, and consecutive blocks stream with no gap on the vertex
// output. Light levels come from three APB registers (full, occluded, underside at byte
// addresses 0, 4, 8); write them only while the block is idle.
`default_nettype none
module voxel_face_cull_occlusion_mesher (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [vfcm_pkg::PADDR_BITS-1:0]     paddr,
    input  wire logic [vfcm_pkg::PDATA_BITS-1:0]     pwdata,
    output logic      [vfcm_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                     pready,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [vfcm_pkg::COORD_BITS-1:0] s_pos_x,
    input  wire logic        [vfcm_pkg::HEIGHT_BITS-1:0] s_pos_y,
    input  wire logic signed [vfcm_pkg::COORD_BITS-1:0] s_pos_z,
    input  wire logic        [vfcm_pkg::NB_BITS-1:0]  s_neighbor_solid,
    input  wire logic        [vfcm_pkg::KIND_BITS-1:0] s_block_kind,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [vfcm_pkg::COORD_BITS:0]     m_vert_x,
    output logic        [vfcm_pkg::HEIGHT_BITS:0]    m_vert_y,
    output logic signed [vfcm_pkg::COORD_BITS:0]     m_vert_z,
    output logic        [vfcm_pkg::LIGHT_BITS-1:0]   m_vert_light,
    output logic        [1:0]                        m_tex_corner,
    output logic        [2:0]                        m_face_id,
    output logic        [vfcm_pkg::KIND_BITS-1:0]    m_kind_out,
    output logic                                     m_last_vertex
);

    vfcm_pkg::light_cfg_t cfg_reg;
    vfcm_pkg::entry_t q_in, q_head;
    logic q_push, q_full, q_pop, q_not_empty;
    logic [1:0] reg_idx;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_light      <= vfcm_pkg::FULL_LIGHT_RST;
            cfg_reg.occluded_light  <= vfcm_pkg::OCCLUDED_LIGHT_RST;
            cfg_reg.underside_light <= vfcm_pkg::UNDERSIDE_LIGHT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                vfcm_pkg::REG_FULL_LIGHT: begin
                    cfg_reg.full_light <= pwdata[vfcm_pkg::LIGHT_BITS-1:0];
                end
                vfcm_pkg::REG_OCCLUDED_LIGHT: begin
                    cfg_reg.occluded_light <= pwdata[vfcm_pkg::LIGHT_BITS-1:0];
                end
                vfcm_pkg::REG_UNDERSIDE_LIGHT: begin
                    cfg_reg.underside_light <= pwdata[vfcm_pkg::LIGHT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            vfcm_pkg::REG_FULL_LIGHT:      prdata[vfcm_pkg::LIGHT_BITS-1:0] = cfg_reg.full_light;
            vfcm_pkg::REG_OCCLUDED_LIGHT:  prdata[vfcm_pkg::LIGHT_BITS-1:0] = cfg_reg.occluded_light;
            vfcm_pkg::REG_UNDERSIDE_LIGHT: prdata[vfcm_pkg::LIGHT_BITS-1:0] = cfg_reg.underside_light;
            default:                       prdata = '0;
        endcase
    end

    vfcm_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_neighbor_solid (s_neighbor_solid),
        .s_block_kind     (s_block_kind),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_entry          (q_in)
    );

    vfcm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    vfcm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vert_x      (m_vert_x),
        .m_vert_y      (m_vert_y),
        .m_vert_z      (m_vert_z),
        .m_vert_light  (m_vert_light),
        .m_tex_corner  (m_tex_corner),
        .m_face_id     (m_face_id),
        .m_kind_out    (m_kind_out),
        .m_last_vertex (m_last_vertex)
    );

endmodule
`default_nettype wire

### hdl/vfcm_checker.sv
// Port-level checks of the voxel face mesher, bound to the top level.
`default_nettype none
module vfcm_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [1:0]                       m_tex_corner,
    input wire logic [2:0]                       m_face_id,
    input wire logic [vfcm_pkg::HEIGHT_BITS:0]   m_vert_y,
    input wire logic                             m_last_vertex
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("vertex valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("vertex dropped while stalled");

    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_vertex |-> m_tex_corner == 2'd3)
        else $error("last vertex not closing a face");

    a_face_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_face_id <= vfcm_pkg::FACE_BACK)
        else $error("face id out of range");

    a_bottom_above_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_face_id == vfcm_pkg::FACE_BOTTOM |-> m_vert_y != '0)
        else $error("bottom face at floor");

endmodule

bind voxel_face_cull_occlusion_mesher vfcm_checker u_vfcm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_tex_corner  (m_tex_corner),
    .m_face_id     (m_face_id),
    .m_vert_y      (m_vert_y),
    .m_last_vertex (m_last_vertex)
);
`default_nettype wire
